// File: sv/tpgd_pkg.sv
`timescale 1ns / 1ps

package tpgd_pkg;

    localparam int COORD_BITS = 12;
    localparam int SCALE_W    = 16;
    localparam int SPAN_W     = 24;
    localparam int DIST_W     = 59;
    localparam int OUT_SPAN_W = 16;
    localparam int FUNC_W     = 2;
    localparam int COUNT_W    = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam int PROD_W  = COORD_BITS + SCALE_W;
    localparam int SQ_W    = 2 * PROD_W;
    localparam int SUM_W   = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;
    localparam int SPEXT_W = (PROD_W > SPAN_W) ? PROD_W : SPAN_W;

    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_X     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_Y     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_SCALE_X = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_SCALE_Y = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOVE_THRESH = 3'd4;

    localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd256;
    localparam logic [SPAN_W-1:0]  THRESH_RESET = 24'd256;
    localparam logic [COUNT_W-1:0] MIN_FINGERS  = 4'd2;

    typedef struct packed {
        logic load;
        logic scale;
        logic square;
        logic finish;
    } t_dp_cmd;

endpackage

// File: sv/tpgd_ctrl.sv
`timescale 1ns / 1ps

module tpgd_ctrl
    import tpgd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SQUARE,
        ST_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;

    assign o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.scale  = (r_state == ST_SCALE);
    assign o_cmd.square = (r_state == ST_SQUARE);
    assign o_cmd.finish = (r_state == ST_FINISH) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    r_state <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_SCALE))
        else $error("accepted beat did not start the sequence");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished beat not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.finish && r_out_valid && !i_out_ready))
        else $error("pending result overwritten");

    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) && !w_out_free |=> (r_state == ST_FINISH))
        else $error("left finish with result blocked");
`endif

endmodule

// File: sv/tpgd_datapath.sv
`timescale 1ns / 1ps

module tpgd_datapath
    import tpgd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [COUNT_W-1:0]      i_active_count,
    input  logic [COORD_BITS-1:0]   i_first_x,
    input  logic [COORD_BITS-1:0]   i_first_y,
    input  logic [COORD_BITS-1:0]   i_second_x,
    input  logic [COORD_BITS-1:0]   i_second_y,
    output logic                    o_report,
    output logic                    o_zoom_out,
    output logic [OUT_SPAN_W-1:0]   o_span_x,
    output logic [OUT_SPAN_W-1:0]   o_span_y
);

    localparam logic [DIST_W-1:0]  DIST_MAX   = '1;
    localparam logic [SUM_W-1:0]   DIST_MAX_W = SUM_W'(DIST_MAX);
    localparam logic [SPAN_W-1:0]  SPAN_MAX   = '1;
    localparam logic [SPEXT_W-1:0] SPAN_MAX_W = SPEXT_W'(SPAN_MAX);

    // configuration
    logic [SCALE_W-1:0] r_scale_x, r_scale_y, r_inv_x, r_inv_y;
    logic [SPAN_W-1:0]  r_thresh;

    // gesture state
    logic [SPAN_W-1:0]  r_span_x, r_span_y;
    logic [DIST_W-1:0]  r_dist;

    // per-beat pipeline
    logic [FUNC_W-1:0]     r_func;
    logic                  r_two;
    logic [COORD_BITS-1:0] r_adx, r_ady;
    logic [PROD_W-1:0]     r_px, r_py;
    logic [SQ_W-1:0]       r_sqx, r_sqy;
    logic [SPAN_W-1:0]     r_spx, r_spy;

    // result payload
    logic                  r_report, r_zoom_out;
    logic [OUT_SPAN_W-1:0] r_out_x, r_out_y;

    logic [COORD_BITS-1:0] n_adx, n_ady;
    logic [SCALE_W-1:0]    w_mul_x, w_mul_y;
    logic [SPEXT_W-1:0]    w_px_e, w_py_e;
    logic [SUM_W-1:0]      w_sqx_e, w_sqy_e, w_sqx_s, w_sqy_s, w_sum;
    logic [DIST_W-1:0]     w_dist_new;
    logic [SPAN_W-1:0]     w_ddx, w_ddy;
    logic                  w_moved, w_spans_zero;

    assign n_adx = (i_second_x >= i_first_x) ? (i_second_x - i_first_x)
                                             : (i_first_x - i_second_x);
    assign n_ady = (i_second_y >= i_first_y) ? (i_second_y - i_first_y)
                                             : (i_first_y - i_second_y);

    assign w_mul_x = (r_func == FUNC_CHECK) ? r_inv_x : r_scale_x;
    assign w_mul_y = (r_func == FUNC_CHECK) ? r_inv_y : r_scale_y;

    assign w_px_e = SPEXT_W'(r_px);
    assign w_py_e = SPEXT_W'(r_py);

    assign w_sqx_e = SUM_W'(r_sqx);
    assign w_sqy_e = SUM_W'(r_sqy);
    assign w_sqx_s = (w_sqx_e > DIST_MAX_W) ? DIST_MAX_W : w_sqx_e;
    assign w_sqy_s = (w_sqy_e > DIST_MAX_W) ? DIST_MAX_W : w_sqy_e;
    assign w_sum   = w_sqx_s + w_sqy_s;
    assign w_dist_new = !r_two ? '0 :
                        (w_sum > DIST_MAX_W) ? DIST_MAX : w_sum[DIST_W-1:0];

    assign w_ddx = (r_spx >= r_span_x) ? (r_spx - r_span_x) : (r_span_x - r_spx);
    assign w_ddy = (r_spy >= r_span_y) ? (r_spy - r_span_y) : (r_span_y - r_spy);
    assign w_moved      = (w_ddx >= r_thresh) || (w_ddy >= r_thresh);
    assign w_spans_zero = (r_span_x == '0) && (r_span_y == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= SCALE_RESET;
            r_scale_y <= SCALE_RESET;
            r_inv_x   <= SCALE_RESET;
            r_inv_y   <= SCALE_RESET;
            r_thresh  <= THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SCALE_X:     r_scale_x <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:     r_scale_y <= i_cfg_data[SCALE_W-1:0];
                CFG_INV_SCALE_X: r_inv_x   <= i_cfg_data[SCALE_W-1:0];
                CFG_INV_SCALE_Y: r_inv_y   <= i_cfg_data[SCALE_W-1:0];
                CFG_MOVE_THRESH: r_thresh  <= i_cfg_data[SPAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_two  <= (i_active_count >= MIN_FINGERS);
            r_adx  <= n_adx;
            r_ady  <= n_ady;
        end
        if (i_cmd.scale) begin
            r_px <= PROD_W'(r_adx) * PROD_W'(w_mul_x);
            r_py <= PROD_W'(r_ady) * PROD_W'(w_mul_y);
        end
        if (i_cmd.square) begin
            r_sqx <= SQ_W'(r_px) * SQ_W'(r_px);
            r_sqy <= SQ_W'(r_py) * SQ_W'(r_py);
            r_spx <= (w_px_e > SPAN_MAX_W) ? SPAN_MAX : w_px_e[SPAN_W-1:0];
            r_spy <= (w_py_e > SPAN_MAX_W) ? SPAN_MAX : w_py_e[SPAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_x <= '0;
            r_span_y <= '0;
            r_dist   <= '0;
        end else if (i_cmd.finish) begin
            case (r_func)
                FUNC_START: begin
                    r_span_x <= '0;
                    r_span_y <= '0;
                    r_dist   <= w_dist_new;
                end
                FUNC_CHECK: begin
                    if (r_two && (w_spans_zero || w_moved)) begin
                        r_span_x <= r_spx;
                        r_span_y <= r_spy;
                    end
                end
                FUNC_EVENT: begin
                    r_dist <= w_dist_new;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_report   <= (r_func == FUNC_CHECK) && r_two && !w_spans_zero && w_moved;
            r_zoom_out <= (r_func == FUNC_EVENT) && (w_dist_new < r_dist);
            r_out_x    <= (r_func == FUNC_EVENT) ? r_span_x[SPAN_W-1 -: OUT_SPAN_W] : '0;
            r_out_y    <= (r_func == FUNC_EVENT) ? r_span_y[SPAN_W-1 -: OUT_SPAN_W] : '0;
        end
    end

    assign o_report   = r_report;
    assign o_zoom_out = r_zoom_out;
    assign o_span_x   = r_out_x;
    assign o_span_y   = r_out_y;

endmodule

// File: sv/touch_pinch_gesture_detector.sv
`timescale 1ns / 1ps

// Two-finger pinch detector. Each input beat carries a function code
// (start, check, event) and one touch frame; each beat yields exactly one
// result beat. From acceptance to a valid result the steps are: latch the
// coordinate differences, the scale multiplies, the squaring multiplies,
// then compare and update state, held while output is blocked. Items
// are processed one at a time; a new item is accepted while the previous
// result still waits in the output register. Configuration writes take
// effect at once and must be made while no item is in flight.

module touch_pinch_gesture_detector
    import tpgd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [COUNT_W-1:0]    i_active_count,
    input  logic [COORD_BITS-1:0] i_first_x,
    input  logic [COORD_BITS-1:0] i_first_y,
    input  logic [COORD_BITS-1:0] i_second_x,
    input  logic [COORD_BITS-1:0] i_second_y,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_report,
    output logic                  o_zoom_out,
    output logic [OUT_SPAN_W-1:0] o_span_x,
    output logic [OUT_SPAN_W-1:0] o_span_y
);

    t_dp_cmd w_cmd;

    tpgd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    tpgd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_active_count (i_active_count),
        .i_first_x      (i_first_x),
        .i_first_y      (i_first_y),
        .i_second_x     (i_second_x),
        .i_second_y     (i_second_y),
        .o_report       (o_report),
        .o_zoom_out     (o_zoom_out),
        .o_span_x       (o_span_x),
        .o_span_y       (o_span_y)
    );

endmodule
